### sv/iau_pkg.sv
package iau_pkg;

  localparam int BW      = 32;           // bound width
  localparam int FB      = 16;           // fraction bits
  localparam int QW      = BW + FB;      // divider quotient / dividend width
  localparam int PW      = 2 * BW;       // full product width
  localparam int FW      = 2 * BW + FB + 1; // rounding datapath width
  localparam int LANES   = 4;
  localparam int QDEPTH  = 2;
  // accept edge to the edge that takes the result
  localparam int LATENCY = QW + 4;

  typedef logic signed [BW-1:0] bound_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_SQR = 3'd4,
    OP_FIX = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_OUTSIDE = 2'd2,
    ST_SAT     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    K_DIRECT = 2'd0,
    K_MUL    = 2'd1,
    K_DIV    = 2'd2
  } kind_t;

  // a rounded, saturated bound
  typedef struct packed {
    logic   sat;
    bound_t val;
  } fin_t;

  // one classified item; lanes 0,1 round down, lanes 2,3 round up
  typedef struct packed {
    kind_t                  kind;
    logic                   sqz;
    bound_t                 zl;
    bound_t                 zu;
    status_t                st;
    bound_t [LANES-1:0]     a;
    bound_t [LANES-1:0]     b;
  } entry_t;

  function automatic logic [BW-1:0] mag(bound_t v);
    return v[BW-1] ? ({BW{1'b0}} - $unsigned(v)) : $unsigned(v);
  endfunction

endpackage

### sv/iau_front.sv
module iau_front import iau_pkg::*; (
  input  logic         start,
  input  logic         full,
  input  logic [2:0]   op,
  input  bound_t       x_low,
  input  bound_t       x_high,
  input  bound_t       y_low,
  input  bound_t       y_high,
  output logic         busy,
  output logic         push,
  output entry_t       entry
);

  // exact add/sub with saturation
  function automatic fin_t sat_sum(bound_t a, bound_t b, logic sub);
    logic signed [BW:0] s;
    fin_t f;
    s = sub ? ({a[BW-1], a} - {b[BW-1], b}) : ({a[BW-1], a} + {b[BW-1], b});
    f.sat = s[BW] != s[BW-1];
    if (f.sat) begin
      f.val = s[BW] ? bound_t'({1'b1, {(BW-1){1'b0}}}) : bound_t'({1'b0, {(BW-1){1'b1}}});
    end else begin
      f.val = s[BW-1:0];
    end
    return f;
  endfunction

  fin_t   lo, hi;
  bound_t lo_a, lo_b, hi_a, hi_b, sm, lg;

  assign busy = full;
  assign push = start && !full;

  always_comb begin
    entry.kind = K_DIRECT;
    entry.sqz  = 1'b0;
    entry.zl   = '0;
    entry.zu   = '0;
    entry.st   = ST_OK;
    entry.a    = '0;
    entry.b    = '0;
    lo   = '0;
    hi   = '0;
    lo_a = '0;
    lo_b = '0;
    hi_a = '0;
    hi_b = '0;
    sm   = '0;
    lg   = '0;
    unique case (op)
      OP_ADD, OP_SUB: begin
        if (op == OP_ADD) begin
          lo = sat_sum(x_low, y_low, 1'b0);
          hi = sat_sum(x_high, y_high, 1'b0);
        end else begin
          lo = sat_sum(x_low, y_high, 1'b1);
          hi = sat_sum(x_high, y_low, 1'b1);
        end
        entry.zl = lo.val;
        entry.zu = hi.val;
        entry.st = (lo.sat || hi.sat) ? ST_SAT : ST_OK;
      end
      OP_MUL: begin
        entry.kind = K_MUL;
        if (x_low >= 0) begin
          lo_a = (y_low >= 0) ? x_low : x_high;   lo_b = y_low;
          hi_a = (y_high <= 0) ? x_low : x_high;  hi_b = y_high;
        end else if (x_high <= 0) begin
          lo_a = (y_high <= 0) ? x_high : x_low;  lo_b = y_high;
          hi_a = (y_low >= 0) ? x_high : x_low;   hi_b = y_low;
        end else if (y_low >= 0) begin
          lo_a = x_low;  lo_b = y_high;
          hi_a = x_high; hi_b = y_high;
        end else if (y_high <= 0) begin
          lo_a = x_high; lo_b = y_low;
          hi_a = x_low;  hi_b = y_low;
        end
        entry.a = {hi_a, hi_a, lo_a, lo_a};
        entry.b = {hi_b, hi_b, lo_b, lo_b};
        // both intervals straddle zero: four candidates
        if (x_low < 0 && x_high > 0 && y_low < 0 && y_high > 0) begin
          entry.a = {x_high, x_low, x_high, x_low};
          entry.b = {y_high, y_low, y_low, y_high};
        end
      end
      OP_DIV: begin
        if (y_low > 0 && y_high > 0) begin
          entry.kind = K_DIV;
          lo_a = x_low;  lo_b = (x_low >= 0) ? y_high : y_low;
          hi_a = x_high; hi_b = (x_high <= 0) ? y_high : y_low;
        end else if (y_low < 0 && y_high < 0) begin
          entry.kind = K_DIV;
          lo_a = x_high; lo_b = (x_high <= 0) ? y_low : y_high;
          hi_a = x_low;  hi_b = (x_low >= 0) ? y_low : y_high;
        end else begin
          entry.st = ST_DIVZERO;
        end
        entry.a = {hi_a, hi_a, lo_a, lo_a};
        entry.b = {hi_b, hi_b, lo_b, lo_b};
      end
      OP_SQR: begin
        entry.kind = K_MUL;
        sm = (mag(x_low) <= mag(x_high)) ? x_low : x_high;
        lg = (mag(x_low) <= mag(x_high)) ? x_high : x_low;
        entry.a   = {lg, lg, sm, sm};
        entry.b   = {lg, lg, sm, sm};
        entry.sqz = (x_low <= 0) && (x_high >= 0);
      end
      OP_FIX: begin
        if (x_low > y_low || y_low > x_high) begin
          entry.zl = x_low;
          entry.zu = x_high;
          entry.st = ST_OUTSIDE;
        end else begin
          entry.zl = y_low;
          entry.zu = y_low;
        end
      end
      default: ;
    endcase
  end

endmodule

### sv/iau_queue.sv
module iau_queue import iau_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  entry_t  din,
  output logic    full,
  output logic    head_valid,
  output entry_t  head
);

  localparam int AW = $clog2(QDEPTH);

  entry_t          mem [QDEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     count, count_next;

  // back end never stalls: the head leaves whenever it is valid
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];
  assign full       = count == (AW+1)'(QDEPTH);
  assign count_next = count + (AW+1)'(push) - (AW+1)'(head_valid);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (head_valid) begin
        rd_ptr <= (rd_ptr == AW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

endmodule

### sv/iau_div.sv
module iau_div import iau_pkg::*; (
  input  logic            clk,
  input  logic [QW-1:0]   num,
  input  logic [BW-1:0]   den,
  output logic [QW-1:0]   quo,
  output logic            inexact
);

  // restoring divider, one quotient bit per stage
  logic [BW-1:0] rem_q [QW];
  logic [QW-1:0] num_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [BW-1:0] den_q [QW];

  logic [BW-1:0] rem_n [QW];
  logic [QW-1:0] num_n [QW];
  logic [QW-1:0] quo_n [QW];
  logic [BW-1:0] den_n [QW];

  always_comb begin
    logic [BW-1:0] r_in, d_in;
    logic [QW-1:0] n_in, q_in;
    logic [BW:0]   t;
    for (int s = 0; s < QW; s++) begin
      if (s == 0) begin
        r_in = '0;
        n_in = num;
        q_in = '0;
        d_in = den;
      end else begin
        r_in = rem_q[s-1];
        n_in = num_q[s-1];
        q_in = quo_q[s-1];
        d_in = den_q[s-1];
      end
      t = {r_in, n_in[QW-1]};
      if (t >= {1'b0, d_in}) begin
        rem_n[s] = BW'(t - {1'b0, d_in});
        quo_n[s] = {q_in[QW-2:0], 1'b1};
      end else begin
        rem_n[s] = t[BW-1:0];
        quo_n[s] = {q_in[QW-2:0], 1'b0};
      end
      num_n[s] = {n_in[QW-2:0], 1'b0};
      den_n[s] = d_in;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < QW; s++) begin
      rem_q[s] <= rem_n[s];
      num_q[s] <= num_n[s];
      quo_q[s] <= quo_n[s];
      den_q[s] <= den_n[s];
    end
  end

  assign quo     = quo_q[QW-1];
  assign inexact = |rem_q[QW-1];

endmodule

### sv/iau_back.sv
module iau_back import iau_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  entry_t   in_entry,
  output logic     out_valid,
  output bound_t   out_zl,
  output bound_t   out_zu,
  output status_t  out_st
);

  localparam logic [PW-1:0] FMASK = (PW'(1) << FB) - PW'(1);

  typedef struct packed {
    kind_t   kind;
    logic    sqz;
    bound_t  zl;
    bound_t  zu;
    status_t st;
    logic    neg0;
    logic    neg2;
  } meta_t;

  // round a magnitude toward the bound's direction, then saturate
  function automatic fin_t finish(logic neg, logic [FW-1:0] m, logic inexact, logic up);
    logic [FW-1:0] m2, lim;
    logic [BW-1:0] v;
    fin_t f;
    m2 = m + FW'(inexact && (neg ? !up : up));
    lim = {{(FW-BW+1){1'b0}}, {(BW-1){1'b1}}} + FW'(neg);
    f.sat = m2 > lim;
    v = f.sat ? lim[BW-1:0] : m2[BW-1:0];
    f.val = neg ? bound_t'({BW{1'b0}} - v) : bound_t'(v);
    return f;
  endfunction

  // stage 1: magnitudes and signs
  logic [BW-1:0]   ma1 [LANES];
  logic [BW-1:0]   mb1 [LANES];
  logic            neg1 [LANES];
  // stage 2: products
  logic [PW-1:0]   prod2 [LANES];
  logic            neg2 [LANES];
  // stage 3 onward: rounded products, aligned with the divider
  fin_t [LANES-1:0] fline [QW];
  meta_t           mline [QW+2];
  logic [QW+1:0]   vline;
  // divider outputs and their rounding
  logic [QW-1:0]   q_lo, q_hi;
  logic            inx_lo, inx_hi;
  fin_t            dfin_lo, dfin_hi;
  fin_t            lo, hi;
  meta_t           m_in, m_end;
  fin_t [LANES-1:0] f_end;

  assign m_in.kind = in_entry.kind;
  assign m_in.sqz  = in_entry.sqz;
  assign m_in.zl   = in_entry.zl;
  assign m_in.zu   = in_entry.zu;
  assign m_in.st   = in_entry.st;
  assign m_in.neg0 = in_entry.a[0][BW-1] ^ in_entry.b[0][BW-1];
  assign m_in.neg2 = in_entry.a[2][BW-1] ^ in_entry.b[2][BW-1];

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      ma1[i]   <= mag(in_entry.a[i]);
      mb1[i]   <= mag(in_entry.b[i]);
      neg1[i]  <= in_entry.a[i][BW-1] ^ in_entry.b[i][BW-1];
      prod2[i] <= PW'(ma1[i]) * PW'(mb1[i]);
      neg2[i]  <= neg1[i];
      fline[0][i] <= finish(neg2[i], FW'(prod2[i] >> FB), |(prod2[i] & FMASK), i >= 2);
    end
    for (int k = 1; k < QW; k++) begin
      fline[k] <= fline[k-1];
    end
    mline[0] <= m_in;
    for (int k = 1; k < QW + 2; k++) begin
      mline[k] <= mline[k-1];
    end
    dfin_lo <= finish(mline[QW].neg0, FW'(q_lo), inx_lo, 1'b0);
    dfin_hi <= finish(mline[QW].neg2, FW'(q_hi), inx_hi, 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vline <= '0;
    end else begin
      vline <= {vline[QW:0], in_valid};
    end
  end

  iau_div u_div_lo (
    .clk     (clk),
    .num     (QW'(ma1[0]) << FB),
    .den     (mb1[0]),
    .quo     (q_lo),
    .inexact (inx_lo)
  );

  iau_div u_div_hi (
    .clk     (clk),
    .num     (QW'(ma1[2]) << FB),
    .den     (mb1[2]),
    .quo     (q_hi),
    .inexact (inx_hi)
  );

  assign m_end = mline[QW+1];
  assign f_end = fline[QW-1];

  always_comb begin
    lo = f_end[1];
    hi = f_end[3];
    if ($signed(f_end[0].val) < $signed(f_end[1].val)) begin
      lo = f_end[0];
    end
    if ($signed(f_end[2].val) > $signed(f_end[3].val)) begin
      hi = f_end[2];
    end
    if (m_end.sqz) begin
      lo = '0;
    end
    if (m_end.kind == K_DIV) begin
      lo = dfin_lo;
      hi = dfin_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vline[QW+1];
    end
    case (m_end.kind)
      K_MUL, K_DIV: begin
        out_zl <= lo.val;
        out_zu <= hi.val;
        out_st <= (lo.sat || hi.sat) ? ST_SAT : ST_OK;
      end
      default: begin
        out_zl <= m_end.zl;
        out_zu <= m_end.zu;
        out_st <= m_end.st;
      end
    endcase
  end

endmodule

### sv/interval_arithmetic_unit_core.sv
// Interval arithmetic unit: add, subtract, multiply, divide, square, fix on Q16.16 bounds.
// Every item taken at an edge with start && !busy gives its result on done; the path runs through
// the 48-stage one-bit-per-stage divider plus rounding and select.
// Throughput: one item every cycle; the receiver cannot stall, so busy stays low.
// Reset: synchronous, active high; clears the queue and all valid bits, none in flight.
module interval_arithmetic_unit_core import iau_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  logic [2:0]   op,
  input  bound_t       x_low,
  input  bound_t       x_high,
  input  bound_t       y_low,
  input  bound_t       y_high,
  output logic         done,
  output bound_t       z_low,
  output bound_t       z_high,
  output logic [1:0]   status
);

  // front: take the item, resolve add/sub/fix/div-by-zero on the spot and
  // pick the operand pairs for the multiply and divide lanes
  logic    push, full, head_valid;
  entry_t  entry, head;
  status_t st;

  iau_front u_front (
    .start  (start),
    .full   (full),
    .op     (op),
    .x_low  (x_low),
    .x_high (x_high),
    .y_low  (y_low),
    .y_high (y_high),
    .busy   (busy),
    .push   (push),
    .entry  (entry)
  );

  // short queue between the two halves
  iau_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .din        (entry),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  // back: four multiplier lanes, two pipelined dividers, directed rounding,
  // min/max of candidates and the status merge; fixed latency for every op
  iau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (head_valid),
    .in_entry  (head),
    .out_valid (done),
    .out_zl    (z_low),
    .out_zu    (z_high),
    .out_st    (st)
  );

  assign status = st;

endmodule

### sv/iau_checker.sv
module iau_checker import iau_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         start,
  input logic         busy,
  input logic         done,
  input bound_t       z_low,
  input bound_t       z_high,
  input logic [1:0]   status
);

  // every taken item comes out after the fixed latency
  a_item_out: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("item taken but no result after fixed latency");

  // no result without an item taken that far back
  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching item");

  // divisor not wholly above or wholly below zero gives a zero interval
  a_divzero: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_DIVZERO |-> z_low == '0 && z_high == '0)
    else $error("divide-by-zero result not zero");

  // back end drains every cycle, so the front never holds off
  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

endmodule

bind interval_arithmetic_unit_core iau_checker u_iau_checker (.*);

### tb/interval_arithmetic_unit_core_tb.sv
`timescale 1ns / 100ps

module interval_arithmetic_unit_core_tb;
  import iau_pkg::*;

  // extremes and handy constants, Q16.16
  localparam bound_t BMAX = 32'sh7FFF_FFFF;
  localparam bound_t BMIN = 32'sh8000_0000;
  localparam bound_t ONE  = 32'sh0001_0000;
  localparam bound_t TWO  = 32'sh0002_0000;
  localparam bound_t HALF = 32'sh0000_8000;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [2:0] op;
  bound_t     x_low, x_high, y_low, y_high;
  logic       done;
  bound_t     z_low, z_high;
  logic [1:0] status;

  interval_arithmetic_unit_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .x_low(x_low), .x_high(x_high), .y_low(y_low), .y_high(y_high),
    .done(done), .z_low(z_low), .z_high(z_high), .status(status)
  );

  typedef struct {
    bound_t zl;
    bound_t zu;
    logic [1:0] st;
  } interval_res_t;

  typedef struct {
    logic [2:0] op;
    bound_t xl, xu, yl, yu;
    bit typed;          // expected result typed into the table
    interval_res_t res;
  } stim_row_t;

  interval_res_t pending_results[$];
  int mismatches = 0;
  int n_directed;
  stim_row_t rows[0:31];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard limit for the run of 425 items with random idle gaps
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  //--------------------------------------------------------------------------
  // Predictor
  //--------------------------------------------------------------------------

  // round a sign-magnitude 128-bit value in the bound's direction, saturate
  function automatic bound_t round_sat(bit neg, logic [127:0] m, bit inexact, bit up,
                                       inout bit sat);
    logic [127:0] lim;
    logic [127:0] v;
    v = m;
    if (inexact && (neg ? !up : up)) v = v + 1;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (v > lim) begin
      sat = 1'b1;
      v = lim;
    end
    return neg ? bound_t'(-v[31:0]) : bound_t'(v[31:0]);
  endfunction

  function automatic bound_t fx_mul(bound_t a, bound_t b, bit up, inout bit sat);
    logic [63:0] ma, mb;
    logic [127:0] p;
    ma = a[31] ? -{{32{a[31]}}, a} : {32'd0, a};
    mb = b[31] ? -{{32{b[31]}}, b} : {32'd0, b};
    p = ma * mb;
    return round_sat(a[31] ^ b[31], p >> FB, p[FB-1:0] != 0, up, sat);
  endfunction

  function automatic bound_t fx_div(bound_t a, bound_t b, bit up, inout bit sat);
    logic [127:0] ma, mb, q, r;
    ma = a[31] ? -{{96{a[31]}}, a} : {96'd0, a};
    mb = b[31] ? -{{96{b[31]}}, b} : {96'd0, b};
    if (mb == 0) return '0;
    ma = ma << FB;
    q = ma / mb;
    r = ma % mb;
    return round_sat(a[31] ^ b[31], q, r != 0, up, sat);
  endfunction

  function automatic bound_t add_sat(longint a, longint b, inout bit sat);
    longint s;
    s = a + b;
    if (s > longint'(BMAX)) begin sat = 1'b1; return BMAX; end
    if (s < longint'(BMIN)) begin sat = 1'b1; return BMIN; end
    return bound_t'(s);
  endfunction

  function automatic interval_res_t predict_interval(logic [2:0] opc, bound_t xl, bound_t xu,
                                                     bound_t yl, bound_t yu);
    interval_res_t r;
    bit sl, su, s1, s2, s3, s4;
    bound_t lu, ul, ll, uu, sm, lg;
    longint mxl, mxu;
    r.zl = '0; r.zu = '0; r.st = ST_OK;
    sl = 0; su = 0; s1 = 0; s2 = 0; s3 = 0; s4 = 0;
    case (opc)
      OP_ADD: begin
        r.zl = add_sat(xl, yl, sl);
        r.zu = add_sat(xu, yu, su);
      end
      OP_SUB: begin
        r.zl = add_sat(xl, -longint'(yu), sl);
        r.zu = add_sat(xu, -longint'(yl), su);
      end
      OP_MUL: begin
        if (xl >= 0) begin
          r.zl = fx_mul(yl >= 0 ? xl : xu, yl, 0, sl);
          r.zu = fx_mul(yu <= 0 ? xl : xu, yu, 1, su);
        end else if (xu <= 0) begin
          r.zl = fx_mul(yu <= 0 ? xu : xl, yu, 0, sl);
          r.zu = fx_mul(yl >= 0 ? xu : xl, yl, 1, su);
        end else if (yl >= 0) begin
          r.zl = fx_mul(xl, yu, 0, sl);
          r.zu = fx_mul(xu, yu, 1, su);
        end else if (yu <= 0) begin
          r.zl = fx_mul(xu, yl, 0, sl);
          r.zu = fx_mul(xl, yl, 1, su);
        end else begin
          lu = fx_mul(xl, yu, 0, s1);
          ul = fx_mul(xu, yl, 0, s2);
          ll = fx_mul(xl, yl, 1, s3);
          uu = fx_mul(xu, yu, 1, s4);
          if (lu < ul) begin r.zl = lu; sl = s1; end else begin r.zl = ul; sl = s2; end
          if (ll > uu) begin r.zu = ll; su = s3; end else begin r.zu = uu; su = s4; end
        end
      end
      OP_DIV: begin
        if (yl > 0 && yu > 0) begin
          r.zl = fx_div(xl, xl >= 0 ? yu : yl, 0, sl);
          r.zu = fx_div(xu, xu <= 0 ? yu : yl, 1, su);
        end else if (yl < 0 && yu < 0) begin
          r.zl = fx_div(xu, xu <= 0 ? yl : yu, 0, sl);
          r.zu = fx_div(xl, xl >= 0 ? yl : yu, 1, su);
        end else begin
          r.st = ST_DIVZERO;
        end
      end
      OP_SQR: begin
        mxl = xl < 0 ? -longint'(xl) : longint'(xl);
        mxu = xu < 0 ? -longint'(xu) : longint'(xu);
        sm = mxl <= mxu ? xl : xu;
        lg = mxl <= mxu ? xu : xl;
        r.zl = fx_mul(sm, sm, 0, sl);
        r.zu = fx_mul(lg, lg, 1, su);
        if (xl <= 0 && xu >= 0) begin r.zl = '0; sl = 0; end
      end
      OP_FIX: begin
        if (xl > yl || yl > xu) begin
          r.zl = xl; r.zu = xu; r.st = ST_OUTSIDE;
        end else begin
          r.zl = yl; r.zu = yl;
        end
      end
      default: ;  // undefined opcodes give zero, ok
    endcase
    if (r.st == ST_OK && (sl || su)) r.st = ST_SAT;
    return r;
  endfunction

  //--------------------------------------------------------------------------
  // Result checker: done is a one-cycle strobe, sampled at the edge
  //--------------------------------------------------------------------------
  always @(posedge clk) begin
    interval_res_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result z=[%h,%h] st=%0d", $realtime, z_low, z_high,
                   status);
      end else begin
        e = pending_results.pop_front();
        if (z_low !== e.zl || z_high !== e.zu || status !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch exp z=[%h,%h] st=%0d got z=[%h,%h] st=%0d",
                     $realtime, e.zl, e.zu, e.st, z_low, z_high, status);
        end
      end
    end
  end

  //--------------------------------------------------------------------------
  // Stimulus
  //--------------------------------------------------------------------------
  function automatic stim_row_t row(logic [2:0] o, bound_t a, bound_t b, bound_t c,
                                    bound_t d);
    stim_row_t s;
    s.op = o; s.xl = a; s.xu = b; s.yl = c; s.yu = d;
    s.typed = 0; s.res = '{'0, '0, ST_OK};
    return s;
  endfunction

  function automatic stim_row_t trow(logic [2:0] o, bound_t a, bound_t b, bound_t c,
                                     bound_t d, bound_t ezl, bound_t ezu, logic [1:0] est);
    stim_row_t s;
    s = row(o, a, b, c, d);
    s.typed = 1; s.res = '{ezl, ezu, est};
    return s;
  endfunction

  // one item, held until taken; the expectation is queued at the accepting edge
  task automatic send_item(stim_row_t s);
    interval_res_t e;
    e = s.typed ? s.res : predict_interval(s.op, s.xl, s.xu, s.yl, s.yu);
    start  <= 1'b1;
    op     <= s.op;
    x_low  <= s.xl;
    x_high <= s.xu;
    y_low  <= s.yl;
    y_high <= s.yu;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(e);
  endtask

  task automatic idle_burst(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic bound_t rand_bound();
    case ($urandom_range(0, 5))
      0: return bound_t'($urandom);
      1: return bound_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      2: return bound_t'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      3: return $urandom_range(0, 1) ? BMAX - bound_t'($urandom_range(0, 3))
                                     : BMIN + bound_t'($urandom_range(0, 3));
      4: return bound_t'($urandom_range(0, 8)) - 4 <<< 16;
      default: return bound_t'($signed($urandom_range(0, 32'h3FF)) - 512);
    endcase
  endfunction

  initial begin
    stim_row_t s;
    bound_t a, b;
    rst = 1'b1; start = 1'b0; op = '0;
    x_low = '0; x_high = '0; y_low = '0; y_high = '0;

    n_directed = 0;
    // add/sub: exact cases and saturation to both extremes
    rows[n_directed++] = trow(OP_ADD, ONE, TWO, ONE, ONE, TWO, 32'sh0003_0000, ST_OK);
    rows[n_directed++] = trow(OP_ADD, BMIN, BMAX, -1, 1, BMIN, BMAX, ST_SAT);
    rows[n_directed++] = trow(OP_SUB, BMIN, BMAX, BMIN, BMAX, BMIN, BMAX, ST_SAT);
    rows[n_directed++] = row(OP_SUB, -ONE, ONE, -TWO, HALF);
    // multiply: every sign case, rounding, saturation
    rows[n_directed++] = row(OP_MUL, ONE, TWO, HALF, ONE);
    rows[n_directed++] = row(OP_MUL, -TWO, -ONE, -ONE, HALF);
    rows[n_directed++] = row(OP_MUL, -ONE, TWO, HALF, TWO);
    rows[n_directed++] = row(OP_MUL, -ONE, TWO, -TWO, -HALF);
    rows[n_directed++] = row(OP_MUL, -ONE, TWO, -TWO, 32'sh0003_0000);
    rows[n_directed++] = row(OP_MUL, 1, 3, 1, 3);               // rounds both ways
    rows[n_directed++] = row(OP_MUL, BMIN, BMAX, BMIN, BMAX);
    rows[n_directed++] = row(OP_MUL, TWO, ONE, ONE, -ONE);      // inverted intervals
    // divide: both sign cases, divisor containing zero, huge quotient
    rows[n_directed++] = row(OP_DIV, ONE, TWO, 32'sh0003_0000, 32'sh0003_0000);
    rows[n_directed++] = row(OP_DIV, -ONE, TWO, -TWO, -HALF);
    rows[n_directed++] = trow(OP_DIV, ONE, TWO, -ONE, ONE, '0, '0, ST_DIVZERO);
    rows[n_directed++] = trow(OP_DIV, ONE, TWO, '0, ONE, '0, '0, ST_DIVZERO);
    rows[n_directed++] = row(OP_DIV, BMIN, BMAX, 1, 1);
    // square: x straddling zero, all negative, saturated
    rows[n_directed++] = row(OP_SQR, -TWO, ONE, '0, '0);
    rows[n_directed++] = row(OP_SQR, -TWO, -ONE, '0, '0);
    rows[n_directed++] = row(OP_SQR, BMIN, BMIN, '0, '0);
    // fix: inside, below, above
    rows[n_directed++] = trow(OP_FIX, -ONE, ONE, HALF, '0, HALF, HALF, ST_OK);
    rows[n_directed++] = trow(OP_FIX, -ONE, ONE, -TWO, '0, -ONE, ONE, ST_OUTSIDE);
    rows[n_directed++] = trow(OP_FIX, -ONE, ONE, TWO, BMAX, -ONE, ONE, ST_OUTSIDE);
    // undefined opcodes
    rows[n_directed++] = trow(3'd6, BMAX, BMAX, BMAX, BMAX, '0, '0, ST_OK);
    rows[n_directed++] = trow(3'd7, BMIN, BMIN, BMIN, BMIN, '0, '0, ST_OK);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < n_directed; i++) send_item(rows[i]);
    idle_burst(1);

    // random part; the last 80 items go back to back
    for (int i = 0; i < 400; i++) begin
      if (i == 200) begin
        // drain fully once before going on
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      if (i < 320 && $urandom_range(0, 7) == 0) idle_burst($urandom_range(1, 19));
      s.op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                          : 3'($urandom_range(0, 5));
      a = rand_bound();
      b = rand_bound();
      // mostly well-formed intervals, some inverted
      if ($urandom_range(0, 9) != 0 && a > b) begin s.xl = b; s.xu = a; end
      else begin s.xl = a; s.xu = b; end
      a = rand_bound();
      b = rand_bound();
      if ($urandom_range(0, 9) != 0 && a > b) begin s.yl = b; s.yu = a; end
      else begin s.yl = a; s.yu = b; end
      // fix: usually pick a value near or inside x
      if (s.op == OP_FIX && $urandom_range(0, 2) != 0)
        s.yl = $urandom_range(0, 1) ? s.xl : s.xu - bound_t'($urandom_range(0, 1));
      s.typed = 0;
      send_item(s);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### interval_arithmetic_unit_core.f
sv/iau_pkg.sv
sv/iau_front.sv
sv/iau_queue.sv
sv/iau_div.sv
sv/iau_back.sv
sv/interval_arithmetic_unit_core.sv
sv/iau_checker.sv
tb/interval_arithmetic_unit_core_tb.sv
